// ===== rtl/core/mbe_pkg.sv =====
// Shared types and constants for the modulus block encryption core.
// Used by modulus_block_encrypt; depends on nothing else.
package mbe_pkg;

    localparam int LANES          = 4;
    localparam int LANE_BITS      = 18;
    localparam int REM_BITS_STAGE = 2;
    localparam int REM_STAGES     = 32 / REM_BITS_STAGE;
    localparam int LANE_STAGES    = REM_STAGES + 1;
    localparam int PIPE_STAGES    = LANES * LANE_STAGES;
    localparam int CFG_IDX_W      = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_LANE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_XK01  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_XK23  = 3'd5;

    localparam logic [7:0] SIZE_XOR_KEY = 8'h3D;
    localparam logic [7:0] SUM_XOR_KEY  = 8'hF8;
    localparam logic [3:0] MAX_BYTES    = 4'd8;

    typedef struct packed {
        logic [63:0] plain_block;
        logic [3:0]  valid_bytes;
    } plain_t;

    typedef struct packed {
        logic [63:0] cipher_low;
        logic [23:0] cipher_high;
    } cipher_t;

    // Payload carried down the lane pipeline
    typedef struct packed {
        logic [63:0]                blk;
        logic [3:0]                 nbytes;
        logic [LANES-1:0][17:0]     res;
        logic [31:0]                dvd;
        logic [31:0]                rem;
    } pipe_t;

endpackage

// ===== rtl/core/modulus_block_encrypt.sv =====
// Modulus block encryption core: four chained multiply-modulo lanes, packing, trailer.
// Depends on mbe_pkg.
// An accepted block passes through every lane stage register and then the result register before done is high.
// Throughput: one block per cycle; busy stays low. Each lane is one multiply stage
// followed by 16 remainder stages of 2 bits each, and lanes run one after another.
// The result is shown for one cycle only; the receiver cannot stall.
// Reset clears the valid bits, done and all configuration registers to zero.
module modulus_block_encrypt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mbe_pkg::plain_t                plain,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    output logic                           done,
    output mbe_pkg::cipher_t               cipher
);
    import mbe_pkg::*;

    logic [63:0] modmul_reg [LANES];
    logic [63:0] xk01_reg;
    logic [63:0] xk23_reg;
    logic [31:0] xk [LANES];

    pipe_t       stg_out [PIPE_STAGES];
    logic        vld_out [PIPE_STAGES];
    pipe_t       first_beat;

    logic        done_reg;
    cipher_t     result_reg;
    cipher_t     result_next;

    // One step of restoring remainder, two dividend bits per call
    function automatic logic [63:0] rem_step(logic [31:0] rem_in, logic [31:0] dvd_in,
                                             logic [31:0] md);
        logic [32:0] t;
        logic [31:0] r;
        logic [31:0] d;
        r = rem_in;
        d = dvd_in;
        for (int k = 0; k < REM_BITS_STAGE; k++)
        begin
            t = {r, d[31]};
            d = {d[30:0], 1'b0};
            if (t >= {1'b0, md})
            begin
                t = t - {1'b0, md};
            end
            r = t[31:0];
        end
        return {r, d};
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes drop the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                modmul_reg[i] <= '0;
            end
            xk01_reg <= '0;
            xk23_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LANE0: modmul_reg[0] <= cfg_data;
                CFG_LANE1: modmul_reg[1] <= cfg_data;
                CFG_LANE2: modmul_reg[2] <= cfg_data;
                CFG_LANE3: modmul_reg[3] <= cfg_data;
                CFG_XK01:  xk01_reg      <= cfg_data;
                CFG_XK23:  xk23_reg      <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign xk[0] = xk01_reg[31:0];
    assign xk[1] = xk01_reg[63:32];
    assign xk[2] = xk23_reg[31:0];
    assign xk[3] = xk23_reg[63:32];

    // Form the entry beat, saturating the byte count
    always_comb
    begin
        first_beat        = '0;
        first_beat.blk    = plain.plain_block;
        first_beat.nbytes = (plain.valid_bytes > MAX_BYTES) ? MAX_BYTES : plain.valid_bytes;
    end

    // Lane pipeline: multiply stage then remainder stages, per lane
    for (genvar s = 0; s < PIPE_STAGES; s++)
    begin : g_stage
        localparam int LN   = s / LANE_STAGES;
        localparam int STEP = s % LANE_STAGES;
        localparam int PL   = (LN > 0) ? LN - 1 : 0;

        pipe_t       prv;
        logic        prv_vld;
        pipe_t       stg_next;
        pipe_t       stg_reg;
        logic        vld_reg;
        logic [31:0] md;
        logic [31:0] x;
        logic [63:0] rs;

        if (s == 0)
        begin : g_head
            assign prv     = first_beat;
            assign prv_vld = start && !busy;
        end
        else
        begin : g_body
            assign prv     = stg_out[s-1];
            assign prv_vld = vld_out[s-1];
        end

        always_comb
        begin
            stg_next = prv;
            md       = modmul_reg[LN][63:32];
            x        = '0;
            rs       = '0;
            if (STEP == 0)
            begin
                // Whiten the word, chain the previous lane, multiply mod 2^32
                x = xk[LN] ^ {16'h0, prv.blk[16*LN +: 16]};
                if (LN > 0)
                begin
                    x = x ^ {16'h0, prv.res[PL][15:0]};
                end
                stg_next.dvd = x * modmul_reg[LN][31:0];
                stg_next.rem = '0;
            end
            else
            begin
                rs           = rem_step(prv.rem, prv.dvd, md);
                stg_next.rem = rs[63:32];
                stg_next.dvd = rs[31:0];
                if (STEP == REM_STAGES)
                begin
                    // Zero modulus gives zero
                    stg_next.res[LN] = (md == '0) ? 18'h0 : rs[49:32];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= prv_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            stg_reg <= stg_next;
        end

        assign stg_out[s] = stg_reg;
        assign vld_out[s] = vld_reg;
    end

    // Mix lanes, pack 18-bit fields into bytes, append size and checksum
    always_comb
    begin
        pipe_t       p;
        logic [17:0] r18 [LANES];
        logic [7:0]  cb [11];
        logic [15:0] b0;
        logic [15:0] b1;
        logic [15:0] tp;
        logic [15:0] t;
        logic [7:0]  sum;
        int          o;
        int          sh;
        p = stg_out[PIPE_STAGES-1];
        for (int i = 0; i < LANES - 1; i++)
        begin
            r18[i] = p.res[i] ^ xk[i][17:0] ^ {2'b00, p.res[i+1][15:0]};
        end
        r18[LANES-1] = p.res[LANES-1];
        for (int j = 0; j < 11; j++)
        begin
            cb[j] = '0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            o  = (i * LANE_BITS) / 8;
            sh = (i * LANE_BITS) % 8;
            b0 = {8'h0, r18[i][7:0]};
            b1 = {8'h0, r18[i][15:8]};
            tp = {14'h0, r18[i][17:16]};
            t  = b0 >> sh;
            cb[o] = cb[o] | t[7:0];
            t  = (b0 << (8 - sh)) | (b1 >> sh);
            cb[o+1] = t[7:0];
            t  = ((b1 << (8 - sh)) & 16'h00FF) | (tp << (6 - sh));
            cb[o+2] = t[7:0];
        end
        sum = SUM_XOR_KEY;
        for (int j = 0; j < 8; j++)
        begin
            if (4'(j) < p.nbytes)
            begin
                sum = sum ^ p.blk[8*j +: 8];
            end
        end
        cb[9]  = {4'h0, p.nbytes} ^ SIZE_XOR_KEY ^ sum;
        cb[10] = sum;
        for (int j = 0; j < 8; j++)
        begin
            result_next.cipher_low[8*j +: 8] = cb[j];
        end
        result_next.cipher_high = {cb[10], cb[9], cb[8]};
    end

    // Hold the result for its one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_out[PIPE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign cipher = result_reg;

`ifndef ASSERT_OFF
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> vld_out[0])
        else $error("accepted beat did not enter the pipeline");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(PIPE_STAGES + 1) done)
        else $error("result strobe missing at fixed latency");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_out[PIPE_STAGES-1]))
        else $error("result strobe without a beat in the last stage");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("core refused a beat");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the modulus block encryption core.
// Depends on mbe_pkg and modulus_block_encrypt; predicts each cipher block internally.
`timescale 1ns / 100ps

module testbench;
    import mbe_pkg::*;

    localparam int LATENCY   = 69;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    plain_t      plain;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;
    logic        done;
    cipher_t     cipher;

    modulus_block_encrypt DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .plain(plain),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .cipher(cipher)
    );

    // Predictor copy of the configuration registers
    logic [63:0] lane_modmul [LANES];
    logic [63:0] xk01, xk23;

    plain_t  block_queue [$];
    cipher_t cipher_expected [$];

    int  mismatches = 0;
    int  blocks_sent = 0;
    int  ciphers_seen = 0;
    int  idle_pct = 0;
    int  stall_cycles = 0;
    bit  pause_req = 0;
    bit  stim_done = 0;
    bit  cfg_pending = 0;
    logic [CFG_IDX_W-1:0] cfg_idx_next;
    logic [63:0] cfg_data_next;

    function automatic logic [31:0] lane_key(int i);
        logic [63:0] r;
        r = (i < 2) ? xk01 : xk23;
        return (i & 1) ? r[63:32] : r[31:0];
    endfunction

    // Compute the cipher block for one plaintext beat
    function automatic cipher_t predict_cipher(plain_t p);
        logic [31:0] r [LANES];
        logic [31:0] x, m, d, prod;
        logic [15:0] word;
        logic [87:0] bits;
        logic [7:0]  sum;
        logic [3:0]  nb;
        cipher_t c;
        for (int i = 0; i < LANES; i++) begin
            word = p.plain_block[16*i +: 16];
            m = lane_modmul[i][31:0];
            d = lane_modmul[i][63:32];
            x = lane_key(i) ^ {16'h0, word};
            if (i > 0)
                x ^= {16'h0, r[i-1][15:0]};
            prod = x * m;
            r[i] = (d == 0) ? 32'h0 : prod % d;
        end
        for (int i = 0; i < LANES - 1; i++)
            r[i] = r[i] ^ lane_key(i) ^ {16'h0, r[i+1][15:0]};
        // Pack each 18-bit lane MSB-first per byte stream
        bits = '0;
        for (int i = 0; i < LANES; i++) begin
            logic [17:0] f;
            f = {r[i][7:0], r[i][15:8], r[i][17:16]};
            for (int b = 0; b < 18; b++) begin
                int pos;
                pos = 18*i + b;
                bits[8*(pos/8) + 7 - (pos%8)] = f[17-b];
            end
        end
        nb = (p.valid_bytes > MAX_BYTES) ? MAX_BYTES : p.valid_bytes;
        sum = SUM_XOR_KEY;
        for (int i = 0; i < 8; i++)
            if (i < nb)
                sum ^= p.plain_block[8*i +: 8];
        c.cipher_low  = bits[63:0];
        c.cipher_high = {sum, {4'h0, nb} ^ SIZE_XOR_KEY ^ sum, bits[71:64]};
        return c;
    endfunction

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Driver: present queued blocks, idling at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            plain <= '0;
        end else if (start && !busy) begin
            cipher_expected.push_back(predict_cipher(plain));
            blocks_sent++;
            if (block_queue.size() > 0 && !pause_req && $urandom_range(99) >= idle_pct)
                plain <= block_queue.pop_front();
            else
                start <= 1'b0;
        end else if (!start && block_queue.size() > 0 && !pause_req
                     && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            plain <= block_queue.pop_front();
        end
    end

    // Configuration channel: hold a write until ready
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            cfg_valid <= 1'b0;
            if (cfg_index < 4)
                lane_modmul[cfg_index] = cfg_data;
            else if (cfg_index == CFG_XK01)
                xk01 = cfg_data;
            else if (cfg_index == CFG_XK23)
                xk23 = cfg_data;
            cfg_pending = 0;
        end else if (cfg_pending && !cfg_valid) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_next;
            cfg_data  <= cfg_data_next;
        end
    end

    // Monitor: compare each done beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && done) begin
            cipher_t e;
            ciphers_seen++;
            if (cipher_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cipher beat %h", cipher);
            end else begin
                e = cipher_expected.pop_front();
                if (cipher.cipher_low !== e.cipher_low || cipher.cipher_high !== e.cipher_high) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cipher mismatch: expected %h_%h got %h_%h",
                                 e.cipher_high, e.cipher_low,
                                 cipher.cipher_high, cipher.cipher_low);
                end
            end
        end
    end

    // Watchdog: count cycles with no beat accepted
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else if (!stim_done || cipher_expected.size() > 0 || block_queue.size() > 0)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("watchdog timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic drain();
        while (block_queue.size() > 0 || start || cipher_expected.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_idx_next  = idx;
        cfg_data_next = val;
        cfg_pending   = 1;
        while (cfg_pending)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_block(logic [63:0] b, logic [3:0] n);
        plain_t p;
        p.plain_block = b;
        p.valid_bytes = n;
        block_queue.push_back(p);
    endtask

    // Pick a lane setting by style: zero, all ones, zero, unit or maximum modulus, or typical
    function automatic logic [63:0] pick_lane(int style);
        case (style)
            0: return 64'h0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return {32'h0, $urandom()};
            3: return {32'h1, $urandom()};
            4: return {32'hFFFF_FFFF, $urandom()};
            default: return {$urandom_range(32'h7FFFF, 2), $urandom()};
        endcase
    endfunction

    task automatic configure(int style);
        for (int i = 0; i < LANES; i++)
            write_reg(i[CFG_IDX_W-1:0], pick_lane(style == 6 ? $urandom_range(6) : style));
        write_reg(CFG_XK01, style == 0 ? 64'h0 : style == 1 ? '1 : rand64());
        write_reg(CFG_XK23, style == 0 ? 64'h0 : style == 1 ? '1 : rand64());
        // Out-of-range indexes must leave the registers alone
        write_reg(3'd6, rand64());
        write_reg(3'd7, rand64());
    endtask

    initial begin
        int phase;
        for (int i = 0; i < LANES; i++) lane_modmul[i] = '0;
        xk01 = '0;
        xk23 = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset settings, then extremes of fields and valid counts
        for (int n = 0; n < 16; n++)
            push_block(n[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0123_4567_89AB_CDEF, n[3:0]);
        drain();
        configure(5);
        push_block(64'h0, 4'd0);
        push_block('1, 4'd15);
        push_block(64'h8000_0000_0000_0001, 4'd8);
        push_block(64'hA5A5_5A5A_FF00_00FF, 4'd9);
        push_block(64'hDEAD_BEEF_0000_0000, 4'd3);
        drain();

        // Random phases across register settings and idling profiles
        for (phase = 0; phase < 12; phase++) begin
            configure(phase % 7);
            idle_pct = (phase < 4) ? 9 : (phase < 8) ? 77 : 0;
            for (int k = 0; k < N_RANDOM / 12; k++)
                push_block(rand64(), $urandom_range(15));
            if (phase == 2) begin
                // Hold the sender until every prediction has landed
                while (block_queue.size() > N_RANDOM / 24) @(posedge clk);
                pause_req = 1;
                while (cipher_expected.size() > 0) @(posedge clk);
                pause_req = 0;
            end
            drain();
        end
        stim_done = 1;

        $display("Sent %0d blocks, checked %0d cipher beats over 14 register settings",
                 blocks_sent, ciphers_seen);
        $display("with zero/unit/max moduli and sender idling at 9, 77 and 0 percent");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
